/* rtl/grc_pkg.sv */
package grc_pkg;

    localparam int MAP_BITS   = 6;
    localparam int FRAC_BITS  = 16;
    localparam int TEX_BITS   = 6;
    localparam int TEX_HEIGHT = 64;
    localparam int DIV_W      = 40;
    localparam int DIVR_W     = 32;
    localparam int CFG_W      = 22;

    localparam logic OP_MAP_WRITE = 1'b0;
    localparam logic OP_CAST      = 1'b1;

    localparam logic [2:0] REG_POS_X   = 3'd0;
    localparam logic [2:0] REG_POS_Y   = 3'd1;
    localparam logic [2:0] REG_DIR_X   = 3'd2;
    localparam logic [2:0] REG_DIR_Y   = 3'd3;
    localparam logic [2:0] REG_PLANE_X = 3'd4;
    localparam logic [2:0] REG_PLANE_Y = 3'd5;
    localparam logic [2:0] REG_WIDTH   = 3'd6;
    localparam logic [2:0] REG_HEIGHT  = 3'd7;

    typedef struct packed {
        logic        operation;
        logic [10:0] column;
        logic [5:0]  cell_x;
        logic [5:0]  cell_y;
        logic        cell_is_wall;
    } in_item_t;

    typedef struct packed {
        logic [10:0] column_out;
        logic        hit_side;
        logic [1:0]  tex_index;
        logic [23:0] perp_distance;
        logic [15:0] line_height;
        logic [10:0] draw_start;
        logic [10:0] draw_end;
        logic [5:0]  tex_x;
        logic [22:0] tex_step;
        logic [22:0] tex_pos_start;
    } out_item_t;

endpackage

/* rtl/grid_ray_caster_column_top.sv */
// A map write is stored as the item is accepted. A cast runs up to 8 divisions on the
// shared 40-step divider, one after another, plus one map memory read per grid cell
// walked. One item is worked on at a time. After reset the map memory is cleared by a
// pass over every cell during which no item is accepted; configuration registers
// return to their reset values at once.
module grid_ray_caster_column_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  grc_pkg::in_item_t           s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output grc_pkg::out_item_t          m_data,
    input  logic                        cfg_we,
    input  logic [2:0]                  cfg_index,
    input  logic [grc_pkg::CFG_W-1:0]   cfg_wdata
);

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_CAM, ST_CAM_W, ST_MUL_RX, ST_MUL_RY, ST_RAY,
        ST_DDX, ST_DDX_W, ST_SDX, ST_SDX_W, ST_DDY, ST_DDY_W, ST_SDY, ST_SDY_W,
        ST_WALK, ST_LOOK, ST_PERP, ST_PERP_W, ST_LH, ST_LH_W, ST_MUL_WALL,
        ST_TSTEP, ST_TSTEP_W, ST_MUL_TPOS, ST_DONE
    } state_t;

    state_t state_reg;

    logic [21:0]        pos_x_reg, pos_y_reg;
    logic signed [17:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;
    logic [11:0]        width_reg, height_reg;

    logic [11:0]        clr_cnt_reg;
    logic [10:0]        column_reg;
    logic signed [29:0] cam_reg;
    logic signed [31:0] rx_reg, ry_reg;
    logic [40:0]        sdx_reg, sdy_reg, ddx_reg, ddy_reg;
    logic signed [7:0]  mx_reg, my_reg;
    logic               side_reg;
    logic [23:0]        perp_reg;
    logic [15:0]        lh_reg;
    logic [5:0]         tx_reg;
    logic [22:0]        tstep_reg;
    logic               m_valid_reg;
    grc_pkg::out_item_t m_data_reg;

    // Map memory and its registered read port.
    logic                                   wall_mem [2**(2*grc_pkg::MAP_BITS)];
    logic [2*grc_pkg::MAP_BITS-1:0]         mem_waddr, mem_raddr;
    logic                                   mem_we, mem_wdata, mem_rdata_reg;

    logic                       div_start, div_done;
    logic [grc_pkg::DIV_W-1:0]  div_dvd, div_q;
    logic [grc_pkg::DIVR_W-1:0] div_dvs;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_reg;
    logic               mul_en;

    logic [31:0]        arx, ary;
    logic               enx, eny, rx_neg, ry_neg, rx_pos, ry_pos, step_x;
    logic signed [7:0]  mx_nx, my_nx;
    logic [16:0]        dist_x, dist_y;
    logic signed [7:0]  m_sel, m_adj;
    logic signed [25:0] edge_d;
    logic [23:0]        abs_d;
    logic [10:0]        h2, ds;
    logic [14:0]        l2, tpos_a;
    logic [15:0]        de_raw;
    logic [11:0]        de1;
    logic [10:0]        de;
    logic [15:0]        wall16;
    logic [22:0]        tpos;
    logic [1:0]         tex;
    logic               accept;

    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        arx    = rx_reg[31] ? 32'(-rx_reg) : 32'(rx_reg);
        ary    = ry_reg[31] ? 32'(-ry_reg) : 32'(ry_reg);
        enx    = rx_reg != '0;
        eny    = ry_reg != '0;
        rx_neg = rx_reg[31];
        ry_neg = ry_reg[31];
        rx_pos = enx && !rx_neg;
        ry_pos = eny && !ry_neg;
        step_x = enx && (!eny || (sdx_reg < sdy_reg));
        mx_nx  = step_x ? (rx_neg ? mx_reg - 8'sd1 : mx_reg + 8'sd1) : mx_reg;
        my_nx  = step_x ? my_reg : (ry_neg ? my_reg - 8'sd1 : my_reg + 8'sd1);
        dist_x = rx_neg ? {1'b0, pos_x_reg[15:0]} : 17'h10000 - {1'b0, pos_x_reg[15:0]};
        dist_y = ry_neg ? {1'b0, pos_y_reg[15:0]} : 17'h10000 - {1'b0, pos_y_reg[15:0]};

        // Distance from the camera to the crossed cell edge.
        m_sel  = side_reg ? my_reg : mx_reg;
        m_adj  = m_sel + 8'((side_reg ? ry_neg : rx_neg) ? 1 : 0);
        edge_d = 26'($signed({m_adj, 16'h0000}))
               - $signed({4'b0000, (side_reg ? pos_y_reg : pos_x_reg)});
        abs_d  = edge_d[25] ? 24'(-edge_d) : edge_d[23:0];

        h2     = height_reg[11:1];
        l2     = lh_reg[15:1];
        ds     = (15'(h2) > l2) ? 11'(15'(h2) - l2) : 11'd0;
        tpos_a = (l2 > 15'(h2)) ? l2 - 15'(h2) : 15'd0;
        de_raw = 16'(l2) + 16'(h2);
        de1    = (de_raw >= 16'(height_reg)) ? height_reg - 12'd1 : de_raw[11:0];
        if (height_reg == '0) begin
            de = '0;
        end else if (de1 > 12'd2047) begin
            de = 11'd2047;
        end else begin
            de = de1[10:0];
        end

        wall16 = (side_reg ? pos_x_reg[15:0] : pos_y_reg[15:0]) + mul_reg[31:16];
        tpos   = (mul_reg[63:23] != '0) ? 23'h7FFFFF : mul_reg[22:0];
        if (side_reg) begin
            tex = ry_pos ? 2'd3 : 2'd2;
        end else begin
            tex = rx_pos ? 2'd1 : 2'd0;
        end
    end

    // Divider operands for each division step of the sequence.
    always_comb begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = 32'd1;
        case (state_reg)
            ST_CAM: begin
                div_start = 1'b1;
                div_dvd   = 40'({column_reg, 17'h00000});
                div_dvs   = (width_reg == '0) ? 32'd1 : 32'(width_reg);
            end
            ST_DDX: begin
                div_start = 1'b1;
                div_dvd   = 40'h01_0000_0000;
                div_dvs   = arx;
            end
            ST_SDX: begin
                div_start = 1'b1;
                div_dvd   = 40'({dist_x, 16'h0000});
                div_dvs   = arx;
            end
            ST_DDY: begin
                div_start = 1'b1;
                div_dvd   = 40'h01_0000_0000;
                div_dvs   = ary;
            end
            ST_SDY: begin
                div_start = 1'b1;
                div_dvd   = 40'({dist_y, 16'h0000});
                div_dvs   = ary;
            end
            ST_PERP: begin
                div_start = 1'b1;
                div_dvd   = {abs_d, 16'h0000};
                div_dvs   = side_reg ? ary : arx;
            end
            ST_LH: begin
                div_start = (perp_reg != '0);
                div_dvd   = 40'({height_reg, 16'h0000});
                div_dvs   = 32'(perp_reg);
            end
            ST_TSTEP: begin
                div_start = 1'b1;
                div_dvd   = 40'(grc_pkg::TEX_HEIGHT << grc_pkg::FRAC_BITS);
                div_dvs   = 32'(lh_reg);
            end
            default: ;
        endcase
    end

    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            ST_MUL_RX: begin
                mul_a = 32'(plane_x_reg);
                mul_b = 32'(cam_reg);
            end
            ST_MUL_RY: begin
                mul_a = 32'(plane_y_reg);
                mul_b = 32'(cam_reg);
            end
            ST_MUL_WALL: begin
                mul_a = $signed({8'h00, perp_reg});
                mul_b = side_reg ? rx_reg : ry_reg;
            end
            ST_MUL_TPOS: begin
                mul_a = $signed({17'h00000, tpos_a});
                mul_b = $signed({9'h000, tstep_reg});
            end
            default: mul_en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            mul_reg <= mul_a * mul_b;
        end
    end

    grc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {s_data.cell_x, s_data.cell_y};
        mem_wdata = s_data.cell_is_wall;
        if (state_reg == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = 1'b0;
        end else if (accept && s_data.operation == grc_pkg::OP_MAP_WRITE) begin
            mem_we = 1'b1;
        end
        mem_raddr = {mx_nx[5:0], my_nx[5:0]};
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            wall_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= wall_mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg   <= 22'd2097152;
            pos_y_reg   <= 22'd2097152;
            dir_x_reg   <= -18'sd65536;
            dir_y_reg   <= '0;
            plane_x_reg <= '0;
            plane_y_reg <= 18'sd43254;
            width_reg   <= 12'd640;
            height_reg  <= 12'd480;
        end else if (cfg_we) begin
            case (cfg_index)
                grc_pkg::REG_POS_X:   pos_x_reg   <= cfg_wdata;
                grc_pkg::REG_POS_Y:   pos_y_reg   <= cfg_wdata;
                grc_pkg::REG_DIR_X:   dir_x_reg   <= $signed(cfg_wdata[17:0]);
                grc_pkg::REG_DIR_Y:   dir_y_reg   <= $signed(cfg_wdata[17:0]);
                grc_pkg::REG_PLANE_X: plane_x_reg <= $signed(cfg_wdata[17:0]);
                grc_pkg::REG_PLANE_Y: plane_y_reg <= $signed(cfg_wdata[17:0]);
                grc_pkg::REG_WIDTH:   width_reg   <= cfg_wdata[11:0];
                grc_pkg::REG_HEIGHT:  height_reg  <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == '1) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept && s_data.operation == grc_pkg::OP_CAST) begin
                        column_reg <= s_data.column;
                        state_reg  <= ST_CAM;
                    end
                end
                ST_CAM: state_reg <= ST_CAM_W;
                ST_CAM_W: begin
                    if (div_done) begin
                        cam_reg   <= $signed({1'b0, div_q[28:0]}) - 30'sd65536;
                        state_reg <= ST_MUL_RX;
                    end
                end
                ST_MUL_RX: state_reg <= ST_MUL_RY;
                ST_MUL_RY: begin
                    rx_reg    <= 32'(dir_x_reg) + mul_reg[47:16];
                    state_reg <= ST_RAY;
                end
                ST_RAY: begin
                    ry_reg    <= 32'(dir_y_reg) + mul_reg[47:16];
                    mx_reg    <= $signed({2'b00, pos_x_reg[21:16]});
                    my_reg    <= $signed({2'b00, pos_y_reg[21:16]});
                    side_reg  <= 1'b0;
                    state_reg <= ST_DDX;
                end
                ST_DDX: begin
                    // The y component is settled here; skip axes that never step.
                    if (!enx) begin
                        state_reg <= eny ? ST_DDY : ST_LH;
                        perp_reg  <= 24'hFFFFFF;
                    end else begin
                        state_reg <= ST_DDX_W;
                    end
                end
                ST_DDX_W: begin
                    if (div_done) begin
                        ddx_reg   <= 41'(div_q);
                        state_reg <= ST_SDX;
                    end
                end
                ST_SDX: state_reg <= ST_SDX_W;
                ST_SDX_W: begin
                    if (div_done) begin
                        sdx_reg   <= 41'(div_q);
                        state_reg <= eny ? ST_DDY : ST_WALK;
                    end
                end
                ST_DDY: state_reg <= ST_DDY_W;
                ST_DDY_W: begin
                    if (div_done) begin
                        ddy_reg   <= 41'(div_q);
                        state_reg <= ST_SDY;
                    end
                end
                ST_SDY: state_reg <= ST_SDY_W;
                ST_SDY_W: begin
                    if (div_done) begin
                        sdy_reg   <= 41'(div_q);
                        state_reg <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (step_x) begin
                        sdx_reg  <= sdx_reg + ddx_reg;
                        side_reg <= 1'b0;
                    end else begin
                        sdy_reg  <= sdy_reg + ddy_reg;
                        side_reg <= 1'b1;
                    end
                    mx_reg    <= mx_nx;
                    my_reg    <= my_nx;
                    state_reg <= ST_LOOK;
                end
                ST_LOOK: begin
                    // Cells outside the grid count as walls.
                    if (mx_reg[7:6] != 2'b00 || my_reg[7:6] != 2'b00 || mem_rdata_reg) begin
                        state_reg <= ST_PERP;
                    end else begin
                        state_reg <= ST_WALK;
                    end
                end
                ST_PERP: state_reg <= ST_PERP_W;
                ST_PERP_W: begin
                    if (div_done) begin
                        perp_reg  <= (div_q[39:24] != '0) ? 24'hFFFFFF : div_q[23:0];
                        state_reg <= ST_LH;
                    end
                end
                ST_LH: begin
                    if (perp_reg == '0) begin
                        lh_reg    <= 16'hFFFF;
                        state_reg <= ST_MUL_WALL;
                    end else begin
                        state_reg <= ST_LH_W;
                    end
                end
                ST_LH_W: begin
                    if (div_done) begin
                        if (div_q[39:16] != '0) begin
                            lh_reg <= 16'hFFFF;
                        end else if (div_q[15:0] == '0) begin
                            lh_reg <= 16'd1;
                        end else begin
                            lh_reg <= div_q[15:0];
                        end
                        state_reg <= ST_MUL_WALL;
                    end
                end
                ST_MUL_WALL: state_reg <= ST_TSTEP;
                ST_TSTEP: begin
                    if ((!side_reg && rx_pos) || (side_reg && ry_neg)) begin
                        tx_reg <= ~wall16[15:10];
                    end else begin
                        tx_reg <= wall16[15:10];
                    end
                    state_reg <= ST_TSTEP_W;
                end
                ST_TSTEP_W: begin
                    if (div_done) begin
                        tstep_reg <= div_q[22:0];
                        state_reg <= ST_MUL_TPOS;
                    end
                end
                ST_MUL_TPOS: state_reg <= ST_DONE;
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.column_out    <= column_reg;
                        m_data_reg.hit_side      <= side_reg;
                        m_data_reg.tex_index     <= tex;
                        m_data_reg.perp_distance <= perp_reg;
                        m_data_reg.line_height   <= lh_reg;
                        m_data_reg.draw_start    <= ds;
                        m_data_reg.draw_end      <= de;
                        m_data_reg.tex_x         <= tx_reg;
                        m_data_reg.tex_step      <= tstep_reg;
                        m_data_reg.tex_pos_start <= tpos;
                        state_reg                <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* rtl/grc_div.sv */
module grc_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [grc_pkg::DIV_W-1:0]    dividend,
    input  logic [grc_pkg::DIVR_W-1:0]   divisor,
    output logic                         done,
    output logic [grc_pkg::DIV_W-1:0]    quotient
);

    logic [grc_pkg::DIV_W-1:0]          q_reg, q_next;
    logic [grc_pkg::DIVR_W-1:0]         r_reg, r_next;
    logic [grc_pkg::DIVR_W-1:0]         d_reg;
    logic [$clog2(grc_pkg::DIV_W)-1:0]  cnt_reg;
    logic                               busy_reg, done_reg;
    logic [grc_pkg::DIVR_W:0]           trial;
    logic                               ge;

    // Restoring division, one quotient bit per cycle.
    always_comb begin
        trial  = {r_reg, q_reg[grc_pkg::DIV_W-1]};
        ge     = trial >= {1'b0, d_reg};
        r_next = ge ? grc_pkg::DIVR_W'(trial - {1'b0, d_reg})
                    : trial[grc_pkg::DIVR_W-1:0];
        q_next = {q_reg[grc_pkg::DIV_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                q_reg    <= dividend;
                r_reg    <= '0;
                d_reg    <= divisor;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                q_reg   <= q_next;
                r_reg   <= r_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ($clog2(grc_pkg::DIV_W))'(grc_pkg::DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
